[design/assert_macros.svh]
// Assertion macros shared by the checker files of the blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, skipped while reset is low.
`define BBE_ASSERT_ALWAYS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbe assertion failed");

// Check cons in the cycle after ante, skipped while reset is low.
`define BBE_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbe assertion failed");

// Check cons in the cycle after ante, also across reset.
`define BBE_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bbe assertion failed");

`endif

[design/bbe_pkg.sv]
// Shared types and constants of the 3x3 edge-average blur block.
`default_nettype none
package bbe_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic end_of_row;
        logic end_of_frame;
    } t_res_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_DRD,
        ST_DSH,
        ST_SUM,
        ST_OUT
    } t_state;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int FRAME_W_BITS = 11;
    localparam int FRAME_H_BITS = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 11'd1024;
    localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET = 13'd1024;

endpackage
`default_nettype wire

[design/box_blur_3x3_edge_average.sv]
// Top level of the streaming 3x3 edge-average box blur.
//
// Usage:
//   Input words arrive on i_in_* (valid/ready). mode = 0 carries one RGB pixel of
//   the frame in raster order, mode = 1 is a drain tick that releases one result
//   of the last row once the whole frame has been taken in.
//   Result words leave on o_out_* (valid/ready). Each is the truncated mean of
//   each channel over the 3x3 neighbours inside the frame, with row/frame ends.
//   Results lag the pixels by one row and one pixel; the pixel that closes any row
//   but the first releases two results. Frame size comes from the write port (index 0 width,
//   index 1 height); any write restarts the frame.
// Sequencing:
//   A new input word is taken only while the sequencer is idle, so a pixel or
//   drain tick is finished, its results loaded into the output register, before
//   the next word is taken. The line stores have a single read port (three column
//   reads per drain tick), and each result takes one sum-and-divide pass through
//   the lanes.
// Reset: the sequencer idles, counters clear, the frame returns to 1024 x 1024.
//   The line stores keep their contents; no clearing pass.
// Stall: the output register holds its word; the sequencer waits at the output
//   step with o_in_ready low until the register frees.
`default_nettype none
module box_blur_3x3_edge_average
    import bbe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EWW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EHW = $clog2(MAX_HEIGHT + 1);

    // Control state
    t_state                  r_state, n_state;
    logic [FRAME_W_BITS-1:0] r_frame_width, n_frame_width;
    logic [FRAME_H_BITS-1:0] r_frame_height, n_frame_height;
    logic [CW-1:0]           r_col, n_col;
    logic [RW-1:0]           r_row, n_row;
    logic [CW-1:0]           r_dpos, n_dpos;
    logic                    r_draining, n_draining;
    logic [1:0]              r_k, n_k;
    logic                    r_more, n_more;
    logic [8:0]              r_cur_mask, n_cur_mask;
    logic [8:0]              r_nxt_mask, n_nxt_mask;
    t_res_flags              r_cur_flags, n_cur_flags;

    // Payload state
    t_rgb r_pix;
    t_rgb r_win [3][3];

    // Effective frame size
    logic [EWW-1:0] eff_w;
    logic [EHW-1:0] eff_h;

    // Position flags
    logic [EWW-1:0] col_inc;
    logic [EHW-1:0] row_inc;
    logic [EWW-1:0] dpos_inc;
    logic           row_end;
    logic           frame_end;
    logic           emit_mid;
    logic           emit_end;
    logic           drain_last;
    logic [8:0]     mask_mid;
    logic [8:0]     mask_end;
    logic [8:0]     mask_drain;

    // Sequencer outputs
    logic in_acc;
    logic lane_load;
    logic mem_we;
    logic win_shift;
    logic out_load;

    // Line store ports
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] drain_addr;
    t_rgb          rd_up1;
    t_rgb          rd_up2;

    // Lanes and merge
    logic [8:0][7:0] cells_red;
    logic [8:0][7:0] cells_green;
    logic [8:0][7:0] cells_blue;
    logic [7:0]      mean_red;
    logic [7:0]      mean_green;
    logic [7:0]      mean_blue;
    logic            merge_free;

    function automatic logic [8:0] cell_mask(input logic [2:0] rv, input logic [2:0] cv);
        logic [8:0] m;
        m = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i*3+j] = rv[i] && cv[j];
            end
        end
        return m;
    endfunction

    // Clamp the configured size: zero acts as one, too large saturates
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = EWW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_w = EWW'(MAX_WIDTH);
        end else begin
            eff_w = EWW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = EHW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            eff_h = EHW'(MAX_HEIGHT);
        end else begin
            eff_h = EHW'(r_frame_height);
        end
    end

    // Where the current pixel or drain step sits in the frame
    always_comb begin
        col_inc    = EWW'(r_col) + EWW'(1);
        row_inc    = EHW'(r_row) + EHW'(1);
        dpos_inc   = EWW'(r_dpos) + EWW'(1);
        row_end    = (col_inc >= eff_w);
        frame_end  = row_end && (row_inc >= eff_h);
        emit_mid   = (r_row != '0) && (r_col != '0);
        emit_end   = (r_row != '0) && row_end;
        drain_last = (dpos_inc >= eff_w);
        // rows: bit 0 two above, bit 2 the current row; cols: bit 0 leftmost
        mask_mid   = cell_mask({1'b1, 1'b1, 32'(r_row) >= 32'd2},
                               {1'b1, 1'b1, 32'(r_col) >= 32'd2});
        mask_end   = cell_mask({1'b1, 1'b1, 32'(r_row) >= 32'd2},
                               {1'b1, r_col != '0, 1'b0});
        mask_drain = cell_mask({1'b0, 1'b1, eff_h != EHW'(1)},
                               {!drain_last, 1'b1, r_dpos != '0});
    end

    assign in_acc = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.mode == MODE_PIXEL && !r_draining) begin
                        n_state = ST_PIX;
                    end else if (i_in_data.mode == MODE_DRAIN && r_draining) begin
                        n_state = ST_DRD;
                    end
                end
            end
            ST_PIX: begin
                n_state = (emit_mid || emit_end) ? ST_SUM : ST_IDLE;
            end
            ST_DRD: begin
                if (r_k == 2'd2) begin
                    n_state = ST_DSH;
                end
            end
            ST_DSH: n_state = ST_SUM;
            ST_SUM: n_state = ST_OUT;
            ST_OUT: begin
                if (merge_free) begin
                    n_state = r_more ? ST_SUM : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        lane_load  = 1'b0;
        mem_we     = 1'b0;
        win_shift  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_PIX: begin
                mem_we    = 1'b1;
                win_shift = 1'b1;
            end
            ST_DRD:  win_shift = (r_k != 2'd0);
            ST_DSH:  win_shift = 1'b1;
            ST_SUM:  lane_load = 1'b1;
            ST_OUT:  out_load  = merge_free;
            default: ;
        endcase
    end

    // Counters, pending results and configuration
    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_col          = r_col;
        n_row          = r_row;
        n_dpos         = r_dpos;
        n_draining     = r_draining;
        n_k            = r_k;
        n_more         = r_more;
        n_cur_mask     = r_cur_mask;
        n_nxt_mask     = r_nxt_mask;
        n_cur_flags    = r_cur_flags;
        unique case (r_state)
            ST_IDLE: n_k = 2'd0;
            ST_PIX: begin
                if (frame_end) begin
                    n_col      = '0;
                    n_row      = '0;
                    n_dpos     = '0;
                    n_draining = 1'b1;
                end else if (row_end) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
                // queue the row-end result behind the interior one
                if (emit_mid) begin
                    n_cur_mask  = mask_mid;
                    n_cur_flags = '{end_of_row: 1'b0, end_of_frame: 1'b0};
                    n_more      = emit_end;
                    n_nxt_mask  = mask_end;
                end else begin
                    n_cur_mask  = mask_end;
                    n_cur_flags = '{end_of_row: 1'b1, end_of_frame: 1'b0};
                    n_more      = 1'b0;
                end
            end
            ST_DRD: n_k = r_k + 2'd1;
            ST_DSH: begin
                n_cur_mask  = mask_drain;
                n_cur_flags = '{end_of_row: drain_last, end_of_frame: drain_last};
                n_more      = 1'b0;
                if (drain_last) begin
                    n_draining = 1'b0;
                    n_dpos     = '0;
                end else begin
                    n_dpos = r_dpos + CW'(1);
                end
            end
            ST_SUM: ;
            ST_OUT: begin
                if (merge_free && r_more) begin
                    n_cur_mask  = r_nxt_mask;
                    n_cur_flags = '{end_of_row: 1'b1, end_of_frame: 1'b0};
                    n_more      = 1'b0;
                end
            end
            default: ;
        endcase
        // a register write restarts the frame
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  n_frame_width  = i_cfg_wdata[FRAME_W_BITS-1:0];
                CFG_FRAME_HEIGHT: n_frame_height = i_cfg_wdata[FRAME_H_BITS-1:0];
                default: ;
            endcase
            n_col      = '0;
            n_row      = '0;
            n_dpos     = '0;
            n_draining = 1'b0;
            n_more     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_width  <= FRAME_W_RESET;
            r_frame_height <= FRAME_H_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_dpos         <= '0;
            r_draining     <= 1'b0;
            r_k            <= 2'd0;
            r_more         <= 1'b0;
            r_cur_flags    <= '0;
        end else begin
            r_state        <= n_state;
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_col          <= n_col;
            r_row          <= n_row;
            r_dpos         <= n_dpos;
            r_draining     <= n_draining;
            r_k            <= n_k;
            r_more         <= n_more;
            r_cur_flags    <= n_cur_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_mask <= n_cur_mask;
        r_nxt_mask <= n_nxt_mask;
    end

    // Hold the incoming pixel until it is written to the line store
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix <= '{red:   i_in_data.pix_red,
                       green: i_in_data.pix_green,
                       blue:  i_in_data.pix_blue};
        end
    end

    // Advance the window one column; drain steps shift in stored columns too
    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= rd_up2;
            r_win[1][2] <= rd_up1;
            r_win[2][2] <= r_pix;
        end
    end

    // Drain reads columns d-1, d, d+1; columns outside the frame are masked
    assign drain_addr = r_dpos + CW'(r_k) - CW'(1);
    assign rd_addr    = (r_state == ST_DRD) ? drain_addr : r_col;

    // Store a: row above; store b: two rows above
    bbe_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_col),
        .i_wdata (r_pix),
        .i_raddr (rd_addr),
        .o_rdata (rd_up1)
    );

    bbe_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_col),
        .i_wdata (rd_up1),
        .i_raddr (rd_addr),
        .o_rdata (rd_up2)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cells_red[i*3+j]   = r_win[i][j].red;
                cells_green[i*3+j] = r_win[i][j].green;
                cells_blue[i*3+j]  = r_win[i][j].blue;
            end
        end
    end

    bbe_lane u_lane_red (
        .i_clk   (i_clk),
        .i_load  (lane_load),
        .i_cells (cells_red),
        .i_mask  (r_cur_mask),
        .o_mean  (mean_red)
    );

    bbe_lane u_lane_green (
        .i_clk   (i_clk),
        .i_load  (lane_load),
        .i_cells (cells_green),
        .i_mask  (r_cur_mask),
        .o_mean  (mean_green)
    );

    bbe_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_load  (lane_load),
        .i_cells (cells_blue),
        .i_mask  (r_cur_mask),
        .o_mean  (mean_blue)
    );

    bbe_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_red   (mean_red),
        .i_green (mean_green),
        .i_blue  (mean_blue),
        .i_flags (r_cur_flags),
        .o_free  (merge_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

[design/bbe_line_mem.sv]
// One line store: single write port, single registered read port.
`default_nettype none
module bbe_line_mem
    import bbe_pkg::*;
#(
    parameter int   DEPTH = 1024,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rgb          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_rgb               o_rdata
);

    t_rgb r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[design/bbe_lane.sv]
// One color lane: masked 3x3 sum, then truncating divide by the cell count.
`default_nettype none
module bbe_lane (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire logic [8:0][7:0] i_cells,
    input  wire logic [8:0]      i_mask,
    output logic [7:0]           o_mean
);

    logic [11:0] n_sum;
    logic [3:0]  n_cnt;
    logic [11:0] r_sum;
    logic [3:0]  r_cnt;
    logic [23:0] prod3;
    logic [23:0] prod9;
    logic [11:0] q3;
    logic [11:0] q9;
    logic [11:0] quot;

    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        for (int k = 0; k < 9; k++) begin
            n_sum = n_sum + (i_mask[k] ? 12'(i_cells[k]) : 12'd0);
            n_cnt = n_cnt + 4'(i_mask[k]);
        end
    end

    // hold the sum until the next result is formed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    // reciprocal multiply, exact for sums up to 9 * 255
    always_comb begin
        prod3 = 24'(r_sum) * 24'd2731;
        prod9 = 24'(r_sum) * 24'd3641;
        q3    = 12'(prod3 >> 13);
        q9    = 12'(prod9 >> 15);
        case (r_cnt)
            4'd2:    quot = r_sum >> 1;
            4'd3:    quot = q3;
            4'd4:    quot = r_sum >> 2;
            4'd6:    quot = q3 >> 1;
            4'd9:    quot = q9;
            default: quot = r_sum;
        endcase
    end

    assign o_mean = quot[7:0];

endmodule
`default_nettype wire

[design/bbe_merge.sv]
// Merge stage: packs the three lane means and flags into the output register.
`default_nettype none
module bbe_merge
    import bbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire t_res_flags i_flags,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_word       o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_word r_data;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= '{out_red:      i_red,
                        out_green:    i_green,
                        out_blue:     i_blue,
                        end_of_row:   i_flags.end_of_row,
                        end_of_frame: i_flags.end_of_frame};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[design/bbe_checker.sv]
// Port-level checker for the blur block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module bbe_checker
    import bbe_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_data
);

    logic out_stall;
    logic eof_closes_row;

    assign out_stall      = o_out_valid && !i_out_ready;
    assign eof_closes_row = o_out_data.end_of_row || !o_out_data.end_of_frame;

    // reset empties the output register and reopens the input
    `BBE_ASSERT_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid)
    `BBE_ASSERT_NEXT(a_reset_opens_in, i_clk, !i_rst_n, o_in_ready)

    // a stalled word holds
    `BBE_ASSERT_HOLD(a_out_holds, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))

    // the last result of a frame also closes its row
    `BBE_ASSERT_ALWAYS(a_eof_is_eor, i_clk, i_rst_n, o_out_valid, eof_closes_row)

endmodule

bind box_blur_3x3_edge_average bbe_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
